>>> design/hsl2rgb_pkg.sv
// Shared types, widths, sextant codes and helpers for the HSL to RGB converter.
// No dependencies; every other design file imports this package.
package hsl2rgb_pkg;

   // fixed-point format: FRAC_BITS fraction bits, FX_ONE means 1.0
   localparam int FRAC_BITS = 16;
   localparam int HUE_W     = 16;
   localparam int VAL_W     = FRAC_BITS + 1;
   localparam int SEXT_W    = 3;
   localparam int H6_W      = FRAC_BITS + SEXT_W;
   localparam int CH_W      = 8;

   localparam int REQ_W = ((HUE_W + 2 * VAL_W + 7) / 8) * 8;
   localparam int RSP_W = ((3 * CH_W + 7) / 8) * 8;

   localparam logic [VAL_W-1:0] FX_ONE  = VAL_W'(1) << FRAC_BITS;
   localparam logic [VAL_W-1:0] FX_HALF = VAL_W'(1) << (FRAC_BITS - 1);

   // hue sextants, by which channel holds the chroma top
   localparam logic [SEXT_W-1:0] SEXT_RED_RISE   = 3'd0;
   localparam logic [SEXT_W-1:0] SEXT_GREEN_FALL = 3'd1;
   localparam logic [SEXT_W-1:0] SEXT_GREEN_RISE = 3'd2;
   localparam logic [SEXT_W-1:0] SEXT_BLUE_FALL  = 3'd3;
   localparam logic [SEXT_W-1:0] SEXT_BLUE_RISE  = 3'd4;

   typedef struct packed {
      logic [VAL_W-1:0] lightness;
      logic [VAL_W-1:0] saturation;
      logic [HUE_W-1:0] hue;
   } hsl_type;

   // after chroma stage: top, bottom and span of the channel range
   typedef struct packed {
      logic [VAL_W-1:0]     lightness;
      logic [VAL_W-1:0]     v;
      logic [VAL_W-1:0]     m;
      logic [VAL_W-1:0]     diff;
      logic [SEXT_W-1:0]    sextant;
      logic [FRAC_BITS-1:0] fract;
   } chroma_type;

   // linear channel values, one bit of headroom above 1.0
   typedef struct packed {
      logic [VAL_W:0] red;
      logic [VAL_W:0] green;
      logic [VAL_W:0] blue;
   } lin_rgb_type;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } rgb_type;

   function automatic logic [VAL_W-1:0] clamp_one(input logic [VAL_W:0] x);
      clamp_one = (x > {1'b0, FX_ONE}) ? FX_ONE : x[VAL_W-1:0];
   endfunction

endpackage

>>> design/hsl2rgb_chroma.sv
// Stages 1-2: input clamp, l*s product, hue*6, then chroma top/bottom.
// Depends on hsl2rgb_pkg.
module hsl2rgb_chroma (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  hsl2rgb_pkg::hsl_type    in_pix,
   output logic                    out_valid,
   output hsl2rgb_pkg::chroma_type out_pix
);
   import hsl2rgb_pkg::*;

   // stage 1
   logic [VAL_W-1:0]   s_c, l_c;
   logic [2*VAL_W-1:0] ls_prod;
   logic [H6_W-1:0]    hue_ext;
   logic               v1_ff, v1_in;
   logic [VAL_W-1:0]   l1_ff, s1_ff, ls1_ff;
   logic [H6_W-1:0]    h6_ff, h6_in;

   assign s_c     = clamp_one({1'b0, in_pix.saturation});
   assign l_c     = clamp_one({1'b0, in_pix.lightness});
   assign ls_prod = l_c * s_c;
   assign hue_ext = H6_W'(in_pix.hue[FRAC_BITS-1:0]);
   assign h6_in   = (hue_ext << 2) + (hue_ext << 1);
   assign v1_in   = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         l1_ff  <= l_c;
         s1_ff  <= s_c;
         ls1_ff <= ls_prod[FRAC_BITS +: VAL_W];
         h6_ff  <= h6_in;
      end
   end

   // stage 2
   logic [VAL_W:0]   v_sum, two_l;
   logic [VAL_W-1:0] v_c, m_c;
   logic             v2_ff;
   chroma_type       st2_ff, st2_in;

   // l <= 1/2: l*(1+s) = l + l*s, exact since l*ONE has no fraction
   assign v_sum = (l1_ff <= FX_HALF) ? ({1'b0, l1_ff} + {1'b0, ls1_ff})
                                     : ({1'b0, l1_ff} + {1'b0, s1_ff} - {1'b0, ls1_ff});
   assign v_c   = clamp_one(v_sum);
   assign two_l = {l1_ff, 1'b0};
   assign m_c   = (two_l > {1'b0, v_c}) ? VAL_W'(two_l - {1'b0, v_c}) : '0;

   always_comb begin
      st2_in.lightness = l1_ff;
      st2_in.v         = v_c;
      st2_in.m         = m_c;
      st2_in.diff      = (v_c > m_c) ? (v_c - m_c) : '0;
      st2_in.sextant   = h6_ff[FRAC_BITS +: SEXT_W];
      st2_in.fract     = h6_ff[FRAC_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st2_ff <= st2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_pix   = st2_ff;

endmodule

>>> design/hsl2rgb_blend.sv
// Stages 3-4: span times hue fraction, then mid values and sextant select.
// Depends on hsl2rgb_pkg.
module hsl2rgb_blend (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  hsl2rgb_pkg::chroma_type  in_pix,
   output logic                     out_valid,
   output hsl2rgb_pkg::lin_rgb_type out_pix
);
   import hsl2rgb_pkg::*;

   // stage 3
   logic [VAL_W+FRAC_BITS-1:0] vsf_prod;
   logic                       v3_ff;
   logic [VAL_W-1:0]           l3_ff, top3_ff, bot3_ff, vsf3_ff;
   logic [SEXT_W-1:0]          sext3_ff;

   assign vsf_prod = in_pix.diff * in_pix.fract;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         l3_ff    <= in_pix.lightness;
         top3_ff  <= in_pix.v;
         bot3_ff  <= in_pix.m;
         vsf3_ff  <= vsf_prod[FRAC_BITS +: VAL_W];
         sext3_ff <= in_pix.sextant;
      end
   end

   // stage 4
   logic [VAL_W:0] mid1, mid2, top_x, bot_x, gray_x;
   logic           v4_ff;
   lin_rgb_type    st4_ff, st4_in;

   assign mid1   = {1'b0, bot3_ff} + {1'b0, vsf3_ff};
   assign mid2   = (top3_ff > vsf3_ff) ? {1'b0, top3_ff - vsf3_ff} : '0;
   assign top_x  = {1'b0, top3_ff};
   assign bot_x  = {1'b0, bot3_ff};
   assign gray_x = {1'b0, l3_ff};

   always_comb begin
      st4_in = '{red: gray_x, green: gray_x, blue: gray_x};
      if (top3_ff != '0) begin
         case (sext3_ff)
            SEXT_RED_RISE:   st4_in = '{red: top_x, green: mid1,  blue: bot_x};
            SEXT_GREEN_FALL: st4_in = '{red: mid2,  green: top_x, blue: bot_x};
            SEXT_GREEN_RISE: st4_in = '{red: bot_x, green: top_x, blue: mid1};
            SEXT_BLUE_FALL:  st4_in = '{red: bot_x, green: mid2,  blue: top_x};
            SEXT_BLUE_RISE:  st4_in = '{red: mid1,  green: bot_x, blue: top_x};
            default:         st4_in = '{red: top_x, green: bot_x, blue: mid2};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st4_ff <= st4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_pix   = st4_ff;

endmodule

>>> design/hsl2rgb_quant.sv
// Stage 5: clamp each linear channel to 1.0 and scale to 8 bits (floor x*255).
// Depends on hsl2rgb_pkg.
module hsl2rgb_quant (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  hsl2rgb_pkg::lin_rgb_type in_pix,
   output logic                     out_valid,
   output hsl2rgb_pkg::rgb_type     out_pix
);
   import hsl2rgb_pkg::*;

   function automatic logic [CH_W-1:0] to_byte(input logic [VAL_W:0] x);
      logic [VAL_W-1:0]      c;
      logic [VAL_W+CH_W-1:0] scaled;
      logic [CH_W:0]         whole;
      c      = clamp_one(x);
      // x*255 as x*256 - x
      scaled = {c, {CH_W{1'b0}}} - (VAL_W + CH_W)'(c);
      whole  = scaled[FRAC_BITS +: CH_W + 1];
      to_byte = whole[CH_W] ? {CH_W{1'b1}} : whole[CH_W-1:0];
   endfunction

   logic    v5_ff;
   rgb_type st5_ff, st5_in;

   always_comb begin
      st5_in.red   = to_byte(in_pix.red);
      st5_in.green = to_byte(in_pix.green);
      st5_in.blue  = to_byte(in_pix.blue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st5_ff <= st5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_pix   = st5_ff;

endmodule

>>> design/hsl2rgb_skid.sv
// Output register plus skid entry; ready toward the pipeline is registered.
// Depends on hsl2rgb_pkg.
module hsl2rgb_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  hsl2rgb_pkg::rgb_type in_pix,
   output logic                 in_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hsl2rgb_pkg::rgb_type out_pix
);
   import hsl2rgb_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rgb_type out_data_ff, out_data_in;
   rgb_type skid_data_ff, skid_data_in;
   logic    out_free;

   assign in_ready = !skid_valid_ff;
   assign out_free = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_pix;
         end
      end else if (in_valid && in_ready) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_pix   = out_data_ff;

   // skid entry only ever fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full with output register empty");

   // a request arriving at a stalled output is parked, not dropped
   a_stall_parks: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready && in_valid && in_ready) |=> skid_valid_ff)
      else $error("request lost at stalled output");

   // draining the skid entry moves its data to the output in order
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> (out_valid_ff && !skid_valid_ff
                                        && out_data_ff == $past(skid_data_ff)))
      else $error("skid entry not forwarded to output");

endmodule

>>> design/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB converter: five-stage pipeline plus output skid.
// Depends on hsl2rgb_pkg, hsl2rgb_chroma, hsl2rgb_blend, hsl2rgb_quant, hsl2rgb_skid.
//
// Usage:
//   Request channel (req_*): one hue/saturation/lightness triple per request.
//   Hue is a Q0.16 fraction of a turn; saturation and lightness are Q1.16,
//   values above 1.0 are clamped to 1.0.
//   Response channel (rsp_*): one 8-bit red/green/blue triple per request,
//   each channel floor(value*255), in request order.
//   Path: five pipeline stages (clamp+l*s multiply, chroma top/bottom,
//   span*fraction multiply, sextant select, scale to 8 bits), then the
//   output register that drives rsp_tvalid.
//   Throughput: one pixel per clock while req_tready is high; the two
//   multipliers (17x17 and 17x16 bits) each own a stage, so nothing iterates.
//   Reset (synchronous, active high) clears all valid bits; the block takes
//   requests in the first cycle after reset.
//   Stall: when rsp_tready is low the output holds and the next pixel parks
//   in a skid entry; req_tready then drops (it comes straight from a flop)
//   and the whole pipeline freezes in place until the skid entry drains.
//   Nothing is dropped or repeated.
module hsl_to_rgb_converter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [15:0] hue, [32:16] saturation, [49:33] lightness, [55:50] ignored
   input  logic [hsl2rgb_pkg::REQ_W-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue
   output logic [hsl2rgb_pkg::RSP_W-1:0]  rsp_tdata
);
   import hsl2rgb_pkg::*;

   hsl_type     req_pix;
   chroma_type  chroma_pix;
   lin_rgb_type lin_pix;
   rgb_type     byte_pix, rsp_pix;
   logic        chroma_valid, lin_valid, byte_valid;
   logic        advance;   // whole pipeline steps together

   // unpack request fields, lowest bits first
   assign req_pix.hue        = req_tdata[0 +: HUE_W];
   assign req_pix.saturation = req_tdata[HUE_W +: VAL_W];
   assign req_pix.lightness  = req_tdata[HUE_W + VAL_W +: VAL_W];

   // stage 1-2: clamp, l*s, hue*6, chroma top/bottom/span
   hsl2rgb_chroma u_chroma (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_pix    (req_pix),
      .out_valid (chroma_valid),
      .out_pix   (chroma_pix)
   );

   // stage 3-4: span*fraction, mid values, sextant select, gray case
   hsl2rgb_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (chroma_valid),
      .in_pix    (chroma_pix),
      .out_valid (lin_valid),
      .out_pix   (lin_pix)
   );

   // stage 5: scale to bytes
   hsl2rgb_quant u_quant (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (lin_valid),
      .in_pix    (lin_pix),
      .out_valid (byte_valid),
      .out_pix   (byte_pix)
   );

   // output register + skid; its ready is a flop, so no combinational
   // path runs from rsp_tready back to req_tready
   hsl2rgb_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (byte_valid),
      .in_pix    (byte_pix),
      .in_ready  (advance),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pix   (rsp_pix)
   );

   assign req_tready = advance;

   // pack response, red in the lowest byte
   assign rsp_tdata = RSP_W'({rsp_pix.blue, rsp_pix.green, rsp_pix.red});

endmodule
